### sv/alic_pkg.sv
`default_nettype none
package alic_pkg;

	// transmit counter width
	localparam int COUNT_WIDTH = 16;

	// divider sizing: events quotient is 16 bits, utilization quotient needs count + 7 bits
	localparam int EV_W = 16;
	localparam int DIV_W = (COUNT_WIDTH + 7 > EV_W) ? COUNT_WIDTH + 7 : EV_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	// configuration register indexes
	localparam logic [2:0] REG_START_DELAY = 3'd0;
	localparam logic [2:0] REG_ADAPT_PERIOD = 3'd1;
	localparam logic [2:0] REG_UPPER_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_LOWER_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_INTERVAL_MAX = 3'd4;
	localparam logic [2:0] REG_INTERVAL_MIN = 3'd5;

	// operation codes
	localparam logic [1:0] OP_TX = 2'd0;
	localparam logic [1:0] OP_RX = 2'd1;
	localparam logic [1:0] OP_UPDATE_DONE = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [11:0] current_interval;
	} in_item_t;

	typedef struct packed {
		logic        adapted;
		logic        change_request;
		logic [12:0] new_interval;
		logic [15:0] window_utilization;
		logic [15:0] average_utilization;
		logic        pending_flag;
	} out_item_t;

	// microcode
	typedef logic [3:0] upc_t;

	typedef enum logic [3:0] {
		ACT_LATCH,
		ACT_DISPATCH,
		ACT_LOAD_EV,
		ACT_DIV_STEP,
		ACT_LOAD_UT,
		ACT_UTIL_SAT,
		ACT_AVG,
		ACT_DECIDE,
		ACT_EMIT
	} act_t;

	typedef enum logic [2:0] {
		J_NEVER,
		J_REQ,
		J_NO_ADAPT,
		J_DIV_LAST,
		J_EV_ZERO,
		J_OUT_FREE
	} jcond_t;

	typedef struct packed {
		act_t   act;
		jcond_t jcond;
		upc_t   target;
		logic   adv;
	} uop_t;

	localparam upc_t PC_FETCH = 4'd0;
	localparam upc_t PC_DISPATCH = 4'd1;
	localparam upc_t PC_LOAD_EV = 4'd2;
	localparam upc_t PC_DIV_EV = 4'd3;
	localparam upc_t PC_LOAD_UT = 4'd4;
	localparam upc_t PC_DIV_UT = 4'd5;
	localparam upc_t PC_UTIL_SAT = 4'd6;
	localparam upc_t PC_AVG = 4'd7;
	localparam upc_t PC_DECIDE = 4'd8;
	localparam upc_t PC_EMIT = 4'd9;

	// program ROM: jump to target when the condition holds, else step on if adv, else hold
	function automatic uop_t urom(input upc_t pc);
		uop_t u;
		begin
			unique case (pc)
				PC_FETCH:    u = '{ACT_LATCH, J_REQ, PC_DISPATCH, 1'b0};
				PC_DISPATCH: u = '{ACT_DISPATCH, J_NO_ADAPT, PC_EMIT, 1'b1};
				PC_LOAD_EV:  u = '{ACT_LOAD_EV, J_NEVER, PC_FETCH, 1'b1};
				PC_DIV_EV:   u = '{ACT_DIV_STEP, J_DIV_LAST, PC_LOAD_UT, 1'b0};
				PC_LOAD_UT:  u = '{ACT_LOAD_UT, J_EV_ZERO, PC_AVG, 1'b1};
				PC_DIV_UT:   u = '{ACT_DIV_STEP, J_DIV_LAST, PC_UTIL_SAT, 1'b0};
				PC_UTIL_SAT: u = '{ACT_UTIL_SAT, J_NEVER, PC_FETCH, 1'b1};
				PC_AVG:      u = '{ACT_AVG, J_NEVER, PC_FETCH, 1'b1};
				PC_DECIDE:   u = '{ACT_DECIDE, J_NEVER, PC_FETCH, 1'b1};
				PC_EMIT:     u = '{ACT_EMIT, J_OUT_FREE, PC_FETCH, 1'b0};
				default:     u = '{ACT_EMIT, J_OUT_FREE, PC_FETCH, 1'b0};
			endcase
			return u;
		end
	endfunction

endpackage
`default_nettype wire

### sv/adaptive_link_interval_controller.sv
// Transmit, receive, update and non-adapting ticks go from dispatch straight to emit; an
//   adapting tick runs the events divide, the utilization divide and saturation (skipped
//   when the window has no events), averaging and the decision. A new request is taken in
//   the cycle after the result register loads; a held result delays it further.
// One shared restoring divider, one quotient bit per cycle, serves events and utilization.
// Reset clears the transmit count, countdown, flags, average and output valid; registers return to defaults.
`default_nettype none
module adaptive_link_interval_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire alic_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output alic_pkg::out_item_t       out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [4:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import alic_pkg::*;

	// configuration
	logic [7:0]  start_delay_q;
	logic [5:0]  adapt_period_q;
	logic [6:0]  upper_thr_q;
	logic [6:0]  lower_thr_q;
	logic [11:0] ivl_max_q;
	logic [11:0] ivl_min_q;

	// block state
	logic [COUNT_WIDTH-1:0] tx_q;
	logic [COUNT_WIDTH-1:0] txs_q;
	logic [15:0]            avg_q;
	logic                   waiting_q;
	logic                   started_q;
	logic [7:0]             cd_q;

	// latched request and per-item results
	logic [1:0]  op_q;
	logic [11:0] ivl_q;
	logic        res_adapted_q;
	logic        res_req_q;
	logic [12:0] res_new_q;
	logic [15:0] res_util_q;

	// divider
	logic [DIV_W-1:0]  q_q;
	logic [EV_W-1:0]   rem_q;
	logic [EV_W-1:0]   dvsr_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [EV_W:0]     rem_sh;
	logic [EV_W:0]     rem_sub;
	logic              qbit;

	// sequencer
	upc_t pc_q;
	uop_t uop;
	logic take;
	logic in_fire;
	logic out_free;
	logic out_valid_q;
	out_item_t out_q;
	logic adapt_now;
	logic cfg_wr;
	logic [2:0] cfg_idx;

	// item transforms
	logic [16:0] avg_sum;
	logic [15:0] avg_next;
	logic [12:0] halved;
	logic [12:0] doubled;
	logic [12:0] new_ivl;

	assign pready = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= 8'd30;
			adapt_period_q <= 6'd4;
			upper_thr_q <= 7'd75;
			lower_thr_q <= 7'd25;
			ivl_max_q <= 12'd800;
			ivl_min_q <= 12'd50;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_START_DELAY:     start_delay_q <= pwdata[7:0];
				REG_ADAPT_PERIOD:    adapt_period_q <= pwdata[5:0];
				REG_UPPER_THRESHOLD: upper_thr_q <= pwdata[6:0];
				REG_LOWER_THRESHOLD: lower_thr_q <= pwdata[6:0];
				REG_INTERVAL_MAX:    ivl_max_q <= pwdata[11:0];
				REG_INTERVAL_MIN:    ivl_min_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// config reads
	always_comb begin
		unique case (cfg_idx)
			REG_START_DELAY:     prdata = {24'd0, start_delay_q};
			REG_ADAPT_PERIOD:    prdata = {26'd0, adapt_period_q};
			REG_UPPER_THRESHOLD: prdata = {25'd0, upper_thr_q};
			REG_LOWER_THRESHOLD: prdata = {25'd0, lower_thr_q};
			REG_INTERVAL_MAX:    prdata = {20'd0, ivl_max_q};
			REG_INTERVAL_MIN:    prdata = {20'd0, ivl_min_q};
			default:             prdata = 32'd0;
		endcase
	end

	// handshakes
	assign uop = urom(pc_q);
	assign in_ready = (pc_q == PC_FETCH);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// expiring tick with a usable interval runs the adaptation
	assign adapt_now = (op_q == OP_TICK) && started_q && (cd_q <= 8'd1) && (ivl_q != 12'd0);

	// jump condition
	always_comb begin
		unique case (uop.jcond)
			J_NEVER:    take = 1'b0;
			J_REQ:      take = in_fire;
			J_NO_ADAPT: take = !adapt_now;
			J_DIV_LAST: take = (dcnt_q == DCNT_W'(1));
			J_EV_ZERO:  take = (q_q[EV_W-1:0] == '0);
			J_OUT_FREE: take = out_free;
			default:    take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else if (take) begin
			pc_q <= uop.target;
		end else if (uop.adv) begin
			pc_q <= pc_q + upc_t'(1);
		end
	end

	// restoring divide step
	assign rem_sh = {rem_q, q_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvsr_q};
	assign qbit = (rem_sh >= {1'b0, dvsr_q});

	// averaging and interval choice
	assign avg_sum = {1'b0, res_util_q} + {1'b0, avg_q};
	assign avg_next = (avg_q == 16'd0) ? 16'd50 : avg_sum[16:1];
	assign halved = {2'b00, ivl_q[11:1]};
	assign doubled = {ivl_q, 1'b0};

	always_comb begin
		if (avg_q >= {9'd0, upper_thr_q}) begin
			new_ivl = (halved < {1'b0, ivl_min_q}) ? {1'b0, ivl_min_q} : halved;
		end else if (avg_q <= {9'd0, lower_thr_q}) begin
			new_ivl = (doubled > {1'b0, ivl_max_q}) ? {1'b0, ivl_max_q} : doubled;
		end else begin
			new_ivl = {1'b0, ivl_q};
		end
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= '0;
			avg_q <= 16'd0;
			waiting_q <= 1'b0;
			started_q <= 1'b0;
			cd_q <= 8'd0;
		end else begin
			unique case (uop.act)
				ACT_DISPATCH: begin
					unique case (op_q)
						OP_TX: begin
							if (tx_q != '1) begin
								tx_q <= tx_q + COUNT_WIDTH'(1);
							end
						end
						OP_RX: begin
							if (!started_q) begin
								started_q <= 1'b1;
								cd_q <= start_delay_q;
							end
						end
						OP_UPDATE_DONE: waiting_q <= 1'b0;
						OP_TICK: begin
							if (started_q) begin
								if (cd_q > 8'd1) begin
									cd_q <= cd_q - 8'd1;
								end else begin
									cd_q <= {2'b00, adapt_period_q};
									tx_q <= '0;
								end
							end
						end
						default: ;
					endcase
				end
				ACT_AVG: avg_q <= avg_next;
				ACT_DECIDE: begin
					if (new_ivl != {1'b0, ivl_q} && !waiting_q) begin
						waiting_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// result valid: set on emit, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uop.act == ACT_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (uop.act)
			ACT_LATCH: begin
				if (in_fire) begin
					op_q <= in_data.operation;
					ivl_q <= in_data.current_interval;
				end
			end
			ACT_DISPATCH: begin
				txs_q <= tx_q;
				res_adapted_q <= 1'b0;
				res_req_q <= 1'b0;
				res_new_q <= 13'd0;
				res_util_q <= 16'd0;
			end
			ACT_LOAD_EV: begin
				q_q <= DIV_W'(EV_W'(adapt_period_q) * EV_W'(800)) << (DIV_W - EV_W);
				dvsr_q <= EV_W'(ivl_q);
				rem_q <= '0;
				dcnt_q <= DCNT_W'(EV_W);
			end
			ACT_DIV_STEP: begin
				rem_q <= qbit ? rem_sub[EV_W-1:0] : rem_sh[EV_W-1:0];
				q_q <= {q_q[DIV_W-2:0], qbit};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			ACT_LOAD_UT: begin
				// no events in the window: utilization saturates
				if (q_q[EV_W-1:0] == '0) begin
					res_util_q <= 16'hFFFF;
				end
				dvsr_q <= q_q[EV_W-1:0];
				q_q <= DIV_W'(txs_q) * DIV_W'(100);
				rem_q <= '0;
				dcnt_q <= DCNT_W'(DIV_W);
			end
			ACT_UTIL_SAT: begin
				res_util_q <= (q_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : q_q[15:0];
			end
			ACT_DECIDE: begin
				res_adapted_q <= 1'b1;
				res_new_q <= new_ivl;
				res_req_q <= (new_ivl != {1'b0, ivl_q}) && !waiting_q;
			end
			ACT_EMIT: begin
				if (out_free) begin
					out_q.adapted <= res_adapted_q;
					out_q.change_request <= res_req_q;
					out_q.new_interval <= res_new_q;
					out_q.window_utilization <= res_util_q;
					out_q.average_utilization <= avg_q;
					out_q.pending_flag <= waiting_q;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (pc_q == PC_DISPATCH))
		else $error("accepted request did not reach dispatch");

	a_req_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.change_request) |-> out_data.pending_flag)
		else $error("change request without pending flag");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.adapted) |->
		(out_data.new_interval == 13'd0 && out_data.window_utilization == 16'd0))
		else $error("non-adapting result carries interval or utilization");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_DIV_EV || pc_q == PC_DIV_UT) |-> (dcnt_q != '0))
		else $error("divider stepping with zero count");

endmodule
`default_nettype wire
